/* sv/icls_pkg.sv */
// ----------------------------------------------------------------------------
// icls_pkg: shared types and constants of the idle counter load statistics unit
// Widths, configuration register codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package icls_pkg;

  localparam int NUM_CORES    = 2;
  localparam int COUNTER_BITS = 16;
  localparam int CORE_W       = 1;
  localparam int CORE_IDX_W   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int LOAD_W       = 30;
  localparam int FS_W         = 16;
  localparam int SUM_W        = 32;
  localparam int AVG_W        = SUM_W + 1;
  localparam int PROD_W       = COUNTER_BITS + LOAD_W;
  localparam int CFG_DATA_W   = 30;
  localparam int CFG_IDX_W    = 1;

  localparam int DIV_NUM_W    = 48;
  localparam int DIV_DEN_W    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [FS_W-1:0]   FS_RESET  = 16'hFFFF;
  localparam logic [LOAD_W-1:0] CLK_RESET = 30'd125000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_AVG_WAIT,
    ST_MUL,
    ST_LDIV,
    ST_LDIV_WAIT,
    ST_FINISH
  } state_t;

  // Which load figure is being worked out.
  typedef enum logic [1:0] {
    SEL_MAX_LOAD,
    SEL_MIN_LOAD,
    SEL_AVG_LOAD
  } load_sel_t;

  typedef struct packed {
    logic      capture_in;
    logic      upd_sample;
    logic      div_start_avg;
    logic      cap_avg;
    logic      mul_start;
    logic      div_start_load;
    logic      cap_load;
    logic      finish;
    load_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic core_ok;
    logic tally_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/idle_counter_load_stats_unit.sv */
// ----------------------------------------------------------------------------
// idle_counter_load_stats_unit: per-core load monitor built on idle counters
// Top level joining the sequencing controller and the statistics datapath.
// ----------------------------------------------------------------------------
// A sample item is latched in the idle state and applied in the decode state.
// Unless its core has no samples, a report item runs a 48-step restoring
// divider once for the rounded average delta and once more for each of the
// three load figures, each also needing a multiply state and a divider start
// state. Only one item is in flight at a time; a finished report waits in the
// output register and the next item is taken as soon as that report has been
// handed over by its transfer or stands in the register. Configuration is
// written through cfg_wr_en with index 0 for full scale count and 1 for clock
// frequency, and must only be written while the unit is idle.
module idle_counter_load_stats_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [icls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icls_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [icls_pkg::CORE_W-1:0]       in_core_id,
  input  logic [icls_pkg::COUNTER_BITS-1:0] in_counter_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [icls_pkg::CORE_W-1:0]       out_report_core,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_min,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_avg,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_max,
  output logic                              out_empty_res
);

  icls_pkg::dp_cmd_t    cmd;
  icls_pkg::dp_status_t status;

  icls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  icls_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_core_id       (in_core_id),
    .in_counter_value (in_counter_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_core  (out_report_core),
    .out_load_min     (out_load_min),
    .out_load_avg     (out_load_avg),
    .out_load_max     (out_load_max),
    .out_empty_res    (out_empty_res)
  );

endmodule

/* sv/icls_div.sv */
// ----------------------------------------------------------------------------
// icls_div: iterative restoring divider
// Produces one quotient bit per cycle over the full dividend width and pulses
// done for one cycle once the quotient is ready.
// ----------------------------------------------------------------------------
module icls_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [icls_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [icls_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           done,
  output logic [icls_pkg::DIV_NUM_W-1:0] quotient
);

  localparam logic [icls_pkg::DIV_CNT_W-1:0] LAST_STEP =
    icls_pkg::DIV_CNT_W'(icls_pkg::DIV_NUM_W - 1);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [icls_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [icls_pkg::DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [icls_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [icls_pkg::DIV_DEN_W-1:0] den_r, den_nxt;
  logic [icls_pkg::DIV_DEN_W:0]   trial;
  logic                           fits;

  // The dividend shifts out of the top of the quotient register while the
  // quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[icls_pkg::DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[icls_pkg::DIV_NUM_W-2:0], fits};
      rem_nxt = fits ? icls_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                     : trial[icls_pkg::DIV_DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/icls_datapath.sv */
// ----------------------------------------------------------------------------
// icls_datapath: statistics store, load arithmetic and result register
// Holds the per-core delta statistics and the configuration registers, works
// out the three load figures with one multiplier and the shared divider, and
// presents the report on the result channel.
// ----------------------------------------------------------------------------
module icls_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  icls_pkg::dp_cmd_t                 cmd,
  output icls_pkg::dp_status_t              status,
  input  logic                              cfg_wr_en,
  input  logic [icls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icls_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_command,
  input  logic [icls_pkg::CORE_W-1:0]       in_core_id,
  input  logic [icls_pkg::COUNTER_BITS-1:0] in_counter_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [icls_pkg::CORE_W-1:0]       out_report_core,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_min,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_avg,
  output logic [icls_pkg::LOAD_W-1:0]       out_load_max,
  output logic                              out_empty_res
);

  localparam int CB = icls_pkg::COUNTER_BITS;
  localparam int NC = icls_pkg::NUM_CORES;
  localparam int LW = icls_pkg::LOAD_W;

  // Configuration registers
  logic [icls_pkg::FS_W-1:0] fs_r, fs_nxt;
  logic [LW-1:0]             clk_hz_r, clk_hz_nxt;

  // Per-core statistics
  logic [CB-1:0]             prev_r  [NC];
  logic [CB-1:0]             dmin_r  [NC];
  logic [CB-1:0]             dmax_r  [NC];
  logic [icls_pkg::SUM_W-1:0] dtot_r [NC];
  logic [icls_pkg::SUM_W-1:0] tally_r [NC];

  // Latched item
  logic                          cmd_r;
  logic [icls_pkg::CORE_W-1:0]   core_r;
  logic [CB-1:0]                 cv_r;
  logic [icls_pkg::CORE_IDX_W-1:0] idx;

  // Arithmetic
  logic [icls_pkg::AVG_W-1:0]  avg_r;
  logic [icls_pkg::PROD_W-1:0] prod_r;
  logic                        over_r;
  logic [LW-1:0]               lmin_r, lavg_r, lmax_r;
  logic [icls_pkg::AVG_W-1:0]  delta_sel;
  logic [icls_pkg::FS_W-1:0]   fs_eff;
  logic [LW-1:0]               load_val;
  logic [LW-1:0]               lmin_clamped;
  logic [CB-1:0]               delta;
  logic [icls_pkg::AVG_W-1:0]  avg_num;

  // Divider
  logic                            div_start;
  logic [icls_pkg::DIV_NUM_W-1:0]  div_dividend;
  logic [icls_pkg::DIV_DEN_W-1:0]  div_divisor;
  logic                            div_done;
  logic [icls_pkg::DIV_NUM_W-1:0]  div_quo;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [icls_pkg::CORE_W-1:0] out_core_r;
  logic [LW-1:0]               out_min_r, out_avg_r, out_max_r;
  logic                        out_empty_r;
  logic                        tally_zero;

  assign idx = icls_pkg::CORE_IDX_W'(core_r);

  // ---------------- configuration ----------------
  always_comb begin
    fs_nxt     = fs_r;
    clk_hz_nxt = clk_hz_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        icls_pkg::CFG_FULL_SCALE: fs_nxt     = cfg_data[icls_pkg::FS_W-1:0];
        icls_pkg::CFG_CLOCK_HZ:   clk_hz_nxt = cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r     <= icls_pkg::FS_RESET;
      clk_hz_r <= icls_pkg::CLK_RESET;
    end else begin
      fs_r     <= fs_nxt;
      clk_hz_r <= clk_hz_nxt;
    end
  end

  // A full scale of zero is treated as one.
  assign fs_eff = (fs_r == '0) ? icls_pkg::FS_W'(1) : fs_r;

  // ---------------- item latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      cmd_r  <= in_command;
      core_r <= in_core_id;
      cv_r   <= in_counter_value;
    end
  end

  // ---------------- statistics store ----------------
  assign delta      = cv_r - prev_r[idx];
  assign tally_zero = (tally_r[idx] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NC; c++) begin
        prev_r[c]  <= '0;
        dmin_r[c]  <= '1;
        dmax_r[c]  <= '0;
        dtot_r[c]  <= '0;
        tally_r[c] <= '0;
      end
    end else if (cmd.upd_sample) begin
      prev_r[idx] <= cv_r;
      if (delta < dmin_r[idx]) dmin_r[idx] <= delta;
      if (delta > dmax_r[idx]) dmax_r[idx] <= delta;
      dtot_r[idx]  <= dtot_r[idx] + icls_pkg::SUM_W'(delta);
      tally_r[idx] <= tally_r[idx] + 1'b1;
    end else if (cmd.finish) begin
      // The previous reading survives a report.
      dmin_r[idx]  <= '1;
      dmax_r[idx]  <= '0;
      dtot_r[idx]  <= '0;
      tally_r[idx] <= '0;
    end
  end

  // ---------------- load arithmetic ----------------
  assign avg_num = {1'b0, dtot_r[idx]} + {1'b0, 1'b0, tally_r[idx][icls_pkg::SUM_W-1:1]};

  always_comb begin
    case (cmd.sel)
      icls_pkg::SEL_MAX_LOAD: delta_sel = icls_pkg::AVG_W'(dmin_r[idx]);
      icls_pkg::SEL_MIN_LOAD: delta_sel = icls_pkg::AVG_W'(dmax_r[idx]);
      icls_pkg::SEL_AVG_LOAD: delta_sel = avg_r;
      default:                delta_sel = avg_r;
    endcase
  end

  assign div_start = cmd.div_start_avg | cmd.div_start_load;

  always_comb begin
    if (cmd.div_start_avg) begin
      div_dividend = icls_pkg::DIV_NUM_W'(avg_num);
      div_divisor  = tally_r[idx];
    end else begin
      div_dividend = icls_pkg::DIV_NUM_W'(prod_r);
      div_divisor  = icls_pkg::DIV_DEN_W'(fs_eff);
    end
  end

  icls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // A delta at or above full scale always gives a scaled value of at least
  // clock_hz, so the load saturates to zero and only the low bits of the delta
  // ever reach the multiplier.
  always_ff @(posedge clk) begin
    if (cmd.cap_avg) begin
      avg_r <= div_quo[icls_pkg::AVG_W-1:0];
    end
    if (cmd.mul_start) begin
      over_r <= (delta_sel >= icls_pkg::AVG_W'(fs_eff));
      prod_r <= icls_pkg::PROD_W'(delta_sel[CB-1:0]) * icls_pkg::PROD_W'(clk_hz_r);
    end
  end

  assign load_val = over_r ? '0 : (clk_hz_r - div_quo[LW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.cap_load) begin
      case (cmd.sel)
        icls_pkg::SEL_MAX_LOAD: lmax_r <= load_val;
        icls_pkg::SEL_MIN_LOAD: lmin_r <= load_val;
        icls_pkg::SEL_AVG_LOAD: lavg_r <= load_val;
        default: ;
      endcase
    end
  end

  assign lmin_clamped = (lmin_r > lavg_r) ? lavg_r : lmin_r;

  // ---------------- result register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_core_r  <= core_r;
      out_empty_r <= tally_zero;
      out_min_r   <= tally_zero ? '0 : lmin_clamped;
      out_avg_r   <= tally_zero ? '0 : lavg_r;
      out_max_r   <= tally_zero ? '0 : lmax_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_core = out_core_r;
  assign out_load_min    = out_min_r;
  assign out_load_avg    = out_avg_r;
  assign out_load_max    = out_max_r;
  assign out_empty_res   = out_empty_r;

  // ---------------- status ----------------
  assign status.is_sample  = (cmd_r == icls_pkg::CMD_SAMPLE);
  assign status.core_ok    = (int'(core_r) < NC);
  assign status.tally_zero = tally_zero;
  assign status.div_done   = div_done;
  assign status.out_free   = ~out_valid_r | ~out_stall;

endmodule

/* sv/icls_ctrl.sv */
// ----------------------------------------------------------------------------
// icls_ctrl: sequencing controller
// Accepts one item at a time, applies samples and steps a report through the
// average division and the three load figures before handing it to the
// result register; a report for a core with no samples goes straight there.
// ----------------------------------------------------------------------------
module icls_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  icls_pkg::dp_status_t status,
  output icls_pkg::dp_cmd_t    cmd
);

  icls_pkg::state_t    state_r, state_nxt;
  icls_pkg::load_sel_t sel_r, sel_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      icls_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = icls_pkg::ST_DECODE;
      end
      icls_pkg::ST_DECODE: begin
        if (!status.core_ok || status.is_sample) begin
          state_nxt = icls_pkg::ST_IDLE;
        end else if (status.tally_zero) begin
          state_nxt = icls_pkg::ST_FINISH;
        end else begin
          state_nxt = icls_pkg::ST_AVG_WAIT;
        end
      end
      icls_pkg::ST_AVG_WAIT: begin
        if (status.div_done) begin
          state_nxt = icls_pkg::ST_MUL;
          sel_nxt   = icls_pkg::SEL_MAX_LOAD;
        end
      end
      icls_pkg::ST_MUL: begin
        state_nxt = icls_pkg::ST_LDIV;
      end
      icls_pkg::ST_LDIV: begin
        state_nxt = icls_pkg::ST_LDIV_WAIT;
      end
      icls_pkg::ST_LDIV_WAIT: begin
        if (status.div_done) begin
          unique case (sel_r)
            icls_pkg::SEL_MAX_LOAD: begin
              sel_nxt   = icls_pkg::SEL_MIN_LOAD;
              state_nxt = icls_pkg::ST_MUL;
            end
            icls_pkg::SEL_MIN_LOAD: begin
              sel_nxt   = icls_pkg::SEL_AVG_LOAD;
              state_nxt = icls_pkg::ST_MUL;
            end
            default: begin
              state_nxt = icls_pkg::ST_FINISH;
            end
          endcase
        end
      end
      icls_pkg::ST_FINISH: begin
        if (status.out_free) state_nxt = icls_pkg::ST_IDLE;
      end
      default: state_nxt = icls_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.sel  = sel_r;
    in_stall = 1'b1;
    unique case (state_r)
      icls_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.capture_in = in_valid;
      end
      icls_pkg::ST_DECODE: begin
        cmd.upd_sample    = status.core_ok & status.is_sample;
        cmd.div_start_avg = status.core_ok & ~status.is_sample & ~status.tally_zero;
      end
      icls_pkg::ST_AVG_WAIT:  cmd.cap_avg        = status.div_done;
      icls_pkg::ST_MUL:       cmd.mul_start      = 1'b1;
      icls_pkg::ST_LDIV:      cmd.div_start_load = 1'b1;
      icls_pkg::ST_LDIV_WAIT: cmd.cap_load       = status.div_done;
      icls_pkg::ST_FINISH:    cmd.finish         = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icls_pkg::ST_IDLE;
      sel_r   <= icls_pkg::SEL_MAX_LOAD;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule
